>>> hw/rtl/s39ptw_pkg.sv
// ----------------------------------------------------------------------------
// s39ptw_pkg
// Shared constants and types of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package s39ptw_pkg;

   localparam int FRAMES         = 64;
   localparam int LEVELS         = 3;

   localparam int SLOT_BITS      = 9;
   localparam int FRAME_BITS     = 6;
   localparam int ENTRY_BITS     = 64;
   localparam int VPN_BITS       = 27;
   localparam int PPN_LSB        = 10;
   localparam int PPN_BITS       = 44;
   localparam int VALID_BIT      = 0;

   localparam int FRAME_IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ADDR_BITS      = FRAME_IDX_BITS + SLOT_BITS;
   localparam int DEPTH          = FRAMES * (1 << SLOT_BITS);
   localparam int LVL_BITS       = $clog2(LEVELS);
   localparam int VPN_EXT_BITS   = LEVELS * SLOT_BITS;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_WALK  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [ENTRY_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

   function automatic logic [SLOT_BITS-1:0] level_index(input logic [VPN_BITS-1:0] vpn,
                                                        input logic [LVL_BITS-1:0] lvl);
      logic [VPN_EXT_BITS-1:0] ext;
      ext = VPN_EXT_BITS'(vpn);
      return SLOT_BITS'(ext >> (SLOT_BITS * (LEVELS - 1 - int'(lvl))));
   endfunction

endpackage

>>> hw/rtl/s39ptw_req_if.sv
// ----------------------------------------------------------------------------
// s39ptw_req_if
// Request channel: table writes and walk transactions.
// ----------------------------------------------------------------------------
interface s39ptw_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [s39ptw_pkg::FRAME_BITS-1:0]     frame;
   logic [s39ptw_pkg::SLOT_BITS-1:0]      slot;
   logic [s39ptw_pkg::ENTRY_BITS-1:0]     entry_word;
   logic [s39ptw_pkg::VPN_BITS-1:0]       virt_page;

   modport source (output valid, action, frame, slot, entry_word, virt_page, input ready);
   modport sink   (input valid, action, frame, slot, entry_word, virt_page, output ready);
endinterface

>>> hw/rtl/s39ptw_rsp_if.sv
// ----------------------------------------------------------------------------
// s39ptw_rsp_if
// Response channel: one transaction per completed walk.
// ----------------------------------------------------------------------------
interface s39ptw_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  found;
   logic [s39ptw_pkg::FRAME_BITS-1:0]     leaf_frame;
   logic [s39ptw_pkg::SLOT_BITS-1:0]      leaf_slot;
   logic [s39ptw_pkg::ENTRY_BITS-1:0]     leaf_entry;
   logic                                  bad_frame;

   modport source (output valid, found, leaf_frame, leaf_slot, leaf_entry, bad_frame,
                   input ready);
   modport sink   (input valid, found, leaf_frame, leaf_slot, leaf_entry, bad_frame,
                   output ready);
endinterface

>>> hw/rtl/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Sv39 page table walker over an on-chip table memory of 64 frames.
// ----------------------------------------------------------------------------
// After reset the table memory is zeroed by a sweep over all FRAMES*512 = 32768
// entries; req_if.ready stays low during the sweep while csr writes are still
// taken. A write transaction is issued in its accept cycle and leaves the walker
// idle, so writes can stream back to back. A walk issues its root read in the
// accept cycle and then reads one entry per level; no request is taken while it
// runs. Once the output register has room, a finished walk raises rsp_if.valid
// and the next request is taken in that same cycle; walks that stop early on an
// invalid entry or an out-of-range frame finish sooner. The response sits in an
// output register, so a new request is taken while it waits for rsp_if.ready.
// ----------------------------------------------------------------------------
module sv39_page_table_walker (
   input  logic                                clock,
   input  logic                                reset,
   s39ptw_req_if.sink                          req_if,
   s39ptw_rsp_if.source                        rsp_if,
   input  logic                                csr_wr_en,
   input  logic [s39ptw_pkg::FRAME_BITS-1:0]   csr_wr_data
);
   import s39ptw_pkg::*;

   state_type                state_ff, state_in;
   logic [FRAME_BITS-1:0]    root_ff;
   logic [VPN_BITS-1:0]      vpn_ff, vpn_in;
   logic [FRAME_IDX_BITS-1:0] cur_ff, cur_in;
   logic [LVL_BITS-1:0]      lvl_ff, lvl_in;
   logic                     bad_ff, bad_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [FRAME_BITS-1:0]    leaf_frame_ff, leaf_frame_in;
   logic [SLOT_BITS-1:0]     leaf_slot_ff, leaf_slot_in;
   logic [ENTRY_BITS-1:0]    leaf_entry_ff, leaf_entry_in;
   logic                     bad_frame_ff, bad_frame_in;

   mem_req_type              mem_req;
   logic [ENTRY_BITS-1:0]    rd_data;
   logic                     store_busy;

   logic                     accept;
   logic                     out_free;
   logic [PPN_BITS-1:0]      ppn;
   logic [SLOT_BITS-1:0]     cur_idx;

   s39ptw_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   assign req_if.ready = (state_ff == ST_IDLE) && !store_busy;
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign ppn          = rd_data[PPN_LSB +: PPN_BITS];
   assign cur_idx      = level_index(vpn_ff, lvl_ff);

   always_comb begin
      state_in      = state_ff;
      vpn_in        = vpn_ff;
      cur_in        = cur_ff;
      lvl_in        = lvl_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      found_in      = found_ff;
      leaf_frame_in = leaf_frame_ff;
      leaf_slot_in  = leaf_slot_ff;
      leaf_entry_in = leaf_entry_ff;
      bad_frame_in  = bad_frame_ff;
      mem_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.action == ACTION_WRITE) begin
                  mem_req.wr_en   = (32'(req_if.frame) < FRAMES);
                  mem_req.wr_addr = {FRAME_IDX_BITS'(req_if.frame), req_if.slot};
                  mem_req.wr_data = req_if.entry_word;
               end else begin
                  vpn_in          = req_if.virt_page;
                  cur_in          = FRAME_IDX_BITS'(root_ff);
                  lvl_in          = '0;
                  bad_in          = !(32'(root_ff) < FRAMES);
                  mem_req.rd_en   = (32'(root_ff) < FRAMES);
                  mem_req.rd_addr = {FRAME_IDX_BITS'(root_ff),
                                     level_index(req_if.virt_page, '0)};
                  state_in        = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (bad_ff || !rd_data[VALID_BIT] || (lvl_ff == LVL_BITS'(LEVELS - 1)) ||
                (ppn >= PPN_BITS'(FRAMES))) begin
               // walk ends here, hold until the output stage has room
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  found_in      = 1'b0;
                  leaf_frame_in = '0;
                  leaf_slot_in  = '0;
                  leaf_entry_in = '0;
                  bad_frame_in  = 1'b0;
                  if (bad_ff) begin
                     bad_frame_in = 1'b1;
                  end else if (!rd_data[VALID_BIT]) begin
                     bad_frame_in = 1'b0;
                  end else if (lvl_ff == LVL_BITS'(LEVELS - 1)) begin
                     found_in      = 1'b1;
                     leaf_frame_in = FRAME_BITS'(cur_ff);
                     leaf_slot_in  = cur_idx;
                     leaf_entry_in = rd_data;
                  end else begin
                     bad_frame_in = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               cur_in          = FRAME_IDX_BITS'(ppn);
               lvl_in          = lvl_ff + 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = {FRAME_IDX_BITS'(ppn), level_index(vpn_ff, lvl_ff + 1'b1)};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            root_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      vpn_ff        <= vpn_in;
      cur_ff        <= cur_in;
      lvl_ff        <= lvl_in;
      bad_ff        <= bad_in;
      found_ff      <= found_in;
      leaf_frame_ff <= leaf_frame_in;
      leaf_slot_ff  <= leaf_slot_in;
      leaf_entry_ff <= leaf_entry_in;
      bad_frame_ff  <= bad_frame_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.found      = found_ff;
   assign rsp_if.leaf_frame = leaf_frame_ff;
   assign rsp_if.leaf_slot  = leaf_slot_ff;
   assign rsp_if.leaf_entry = leaf_entry_ff;
   assign rsp_if.bad_frame  = bad_frame_ff;

   a_found_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.found |-> !rsp_if.bad_frame)
      else $error("response both found and bad_frame");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.found |->
         (rsp_if.leaf_entry == '0) && (rsp_if.leaf_frame == '0) && (rsp_if.leaf_slot == '0))
      else $error("miss response carries leaf data");

   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_if.action == ACTION_WALK) |=> (state_ff == ST_WALK))
      else $error("accepted walk did not start");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_if.ready)
      else $error("request taken during table clear");

endmodule

>>> hw/rtl/s39ptw_store.sv
// ----------------------------------------------------------------------------
// s39ptw_store
// Page table memory: one write and one registered read port, zeroed by a
// sweep after reset.
// ----------------------------------------------------------------------------
module s39ptw_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  s39ptw_pkg::mem_req_type               mem_req,
   output logic [s39ptw_pkg::ENTRY_BITS-1:0]     rd_data,
   output logic                                  busy
);
   import s39ptw_pkg::*;

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                  busy_ff, busy_in;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_BITS'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
      wr_en   = busy_ff ? 1'b1 : mem_req.wr_en;
      wr_addr = busy_ff ? clr_cnt_ff : mem_req.wr_addr;
      wr_data = busy_ff ? '0 : mem_req.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Sv39 page table walker. Table writes and walks
// stream in over the request channel while a local copy of the table memory
// and the root register predicts every walk response. Directed paths hit the
// extremes, invalid entries and out-of-range frames. Random phases build
// three-level paths, some with invalid or out-of-range entries, under several roots, mixed with noise.
// ----------------------------------------------------------------------------
module testbench;
   import s39ptw_pkg::*;

   localparam int IDLE_LIMIT   = 100000;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 8;
   localparam int SLOTS        = 1 << SLOT_BITS;

   typedef struct packed {
      logic                  action;
      logic [FRAME_BITS-1:0] frame;
      logic [SLOT_BITS-1:0]  slot;
      logic [ENTRY_BITS-1:0] entry_word;
      logic [VPN_BITS-1:0]   virt_page;
   } ptw_request_type;

   typedef struct packed {
      logic                  found;
      logic [FRAME_BITS-1:0] leaf_frame;
      logic [SLOT_BITS-1:0]  leaf_slot;
      logic [ENTRY_BITS-1:0] leaf_entry;
      logic                  bad_frame;
   } ptw_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [FRAME_BITS-1:0] csr_wr_data;

   s39ptw_req_if req_if ();
   s39ptw_rsp_if rsp_if ();

   sv39_page_table_walker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [ENTRY_BITS-1:0] table_mem [FRAMES][SLOTS];
   logic [FRAME_BITS-1:0] root_frame_q;
   ptw_result_type        pending_walks[$];
   int                    mismatches;
   int                    burst_left;
   bit                    gapless;
   int                    hold_ticket;
   int                    idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic ptw_result_type walk_tables(input logic [VPN_BITS-1:0] vpn);
      ptw_result_type r;
      logic [63:0] vpn_ext;
      logic [PPN_BITS-1:0] cur;
      logic [SLOT_BITS-1:0] idx;
      logic [ENTRY_BITS-1:0] e;
      r = '0;
      vpn_ext = 64'(vpn);
      cur = PPN_BITS'(root_frame_q);
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         idx = SLOT_BITS'(vpn_ext >> (SLOT_BITS * (LEVELS - 1 - lvl)));
         if (cur >= FRAMES) begin
            r.bad_frame = 1'b1;
            return r;
         end
         e = table_mem[cur][idx];
         if (!e[VALID_BIT])
            return r;
         if (lvl == LEVELS - 1) begin
            r.found      = 1'b1;
            r.leaf_frame = cur[FRAME_BITS-1:0];
            r.leaf_slot  = idx;
            r.leaf_entry = e;
            return r;
         end
         cur = e[PPN_LSB +: PPN_BITS];
      end
      return r;
   endfunction

   function automatic void absorb_request(input ptw_request_type it);
      if (it.action == ACTION_WRITE) begin
         if (it.frame < FRAMES)
            table_mem[it.frame][it.slot] = it.entry_word;
      end else begin
         pending_walks.push_back(walk_tables(it.virt_page));
      end
   endfunction

   function automatic logic [ENTRY_BITS-1:0] make_entry(input logic [PPN_BITS-1:0] ppn,
                                                        input logic [9:0] flags,
                                                        input logic [9:0] top);
      return {top, ppn, flags};
   endfunction

   // pointer to the next level, now and then invalid or off the end of the store
   function automatic logic [ENTRY_BITS-1:0] rand_pointer(input logic [FRAME_BITS-1:0] target);
      logic [PPN_BITS-1:0] ppn;
      logic [9:0] flags;
      int pick;
      pick = $urandom_range(0, 15);
      ppn = PPN_BITS'(target);
      if (pick == 0)
         ppn = {12'($urandom), 32'($urandom)};
      else if (pick == 1)
         ppn = PPN_BITS'(FRAMES + $urandom_range(0, 63));
      flags = 10'($urandom);
      flags[VALID_BIT] = (pick != 2);
      return make_entry(ppn, flags, 10'($urandom));
   endfunction

   function automatic logic [ENTRY_BITS-1:0] rand_leaf();
      logic [ENTRY_BITS-1:0] w;
      w = {$urandom, $urandom};
      w[VALID_BIT] = ($urandom_range(0, 7) != 0);
      return w;
   endfunction

   function automatic logic [VPN_BITS-1:0] vpn_of(input logic [SLOT_BITS-1:0] i0,
                                                  input logic [SLOT_BITS-1:0] i1,
                                                  input logic [SLOT_BITS-1:0] i2);
      return {i0, i1, i2};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < 100)
         $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // sender, called right after a rising edge; returns at the accepting edge
   task automatic send_item(input ptw_request_type it);
      int gap;
      if (!gapless && burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 20);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= it.action;
      req_if.frame      <= it.frame;
      req_if.slot       <= it.slot;
      req_if.entry_word <= it.entry_word;
      req_if.virt_page  <= it.virt_page;
      do @(posedge clock); while (!req_if.ready);
      if (burst_left > 0)
         burst_left--;
      absorb_request(it);
   endtask

   task automatic send_write(input logic [FRAME_BITS-1:0] fr, input logic [SLOT_BITS-1:0] sl,
                             input logic [ENTRY_BITS-1:0] word);
      ptw_request_type it;
      it.action     = ACTION_WRITE;
      it.frame      = fr;
      it.slot       = sl;
      it.entry_word = word;
      it.virt_page  = VPN_BITS'($urandom);
      send_item(it);
   endtask

   task automatic send_walk(input logic [VPN_BITS-1:0] vpn);
      ptw_request_type it;
      it.action     = ACTION_WALK;
      it.frame      = FRAME_BITS'($urandom);
      it.slot       = SLOT_BITS'($urandom);
      it.entry_word = {$urandom, $urandom};
      it.virt_page  = vpn;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_root(input logic [FRAME_BITS-1:0] root);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= root;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      root_frame_q = root;
   endtask

   task automatic test_empty_tables();
      set_root('0);
      send_walk('0);
      send_walk('1);
      send_walk(VPN_BITS'($urandom));
   endtask

   task automatic test_directed_paths();
      set_root('0);
      // root entries carry rwx bits and must still be followed
      send_write(0, 0, make_entry(1, 10'h00F, 10'h000));
      send_write(1, 0, make_entry(2, 10'h001, 10'h000));
      send_write(2, 0, '1);
      send_walk(vpn_of(0, 0, 0));
      send_write(0, 511, make_entry(63, 10'h0FF, 10'h3FF));
      send_write(63, 511, make_entry(62, 10'h001, 10'h000));
      send_write(62, 511, 64'h8000_0000_0000_0001);
      send_walk('1);
      send_walk(vpn_of(0, 0, 1));
      // invalid middle entry with every other bit set
      send_write(1, 5, 64'hFFFF_FFFF_FFFF_FFFE);
      send_walk(vpn_of(0, 5, 3));
      // pointers past the last frame
      send_write(0, 3, make_entry(PPN_BITS'(FRAMES), 10'h001, 10'h000));
      send_walk(vpn_of(3, 0, 0));
      send_write(1, 7, make_entry('1, 10'h001, 10'h000));
      send_walk(vpn_of(0, 7, 9));
      send_write(2, 0, 64'h1);
      send_walk(vpn_of(0, 0, 0));
      send_write(1, 0, '0);
      send_walk(vpn_of(0, 0, 0));
   endtask

   task automatic test_root_extremes();
      set_root('1);
      send_walk('1);
      send_walk('0);
      set_root(62);
      send_walk('1);
   endtask

   task automatic test_random_tables();
      logic [FRAME_BITS-1:0] roots[4];
      logic [SLOT_BITS-1:0] i0, i1, i2;
      logic [FRAME_BITS-1:0] f1, f2;
      int count;
      roots = '{'1, FRAME_BITS'($urandom), '0, FRAME_BITS'($urandom)};
      foreach (roots[p]) begin
         set_root(roots[p]);
         count = 0;
         while (count < 175) begin
            i0 = SLOT_BITS'($urandom);
            i1 = SLOT_BITS'($urandom);
            i2 = SLOT_BITS'($urandom);
            f1 = FRAME_BITS'($urandom);
            f2 = FRAME_BITS'($urandom);
            send_write(root_frame_q, i0, rand_pointer(f1));
            send_write(f1, i1, rand_pointer(f2));
            send_write(f2, i2, rand_leaf());
            count += 3;
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 5))
                  0, 1: send_walk(vpn_of(i0, i1, i2));
                  2: send_walk(vpn_of(i0, i1, SLOT_BITS'($urandom)));
                  3: send_walk(vpn_of(i0, SLOT_BITS'($urandom), i2));
                  4: send_walk(VPN_BITS'($urandom));
                  default: send_write(FRAME_BITS'($urandom), SLOT_BITS'($urandom),
                                      {$urandom, $urandom});
               endcase
               count++;
            end
         end
      end
   endtask

   task automatic test_backpressure();
      logic [SLOT_BITS-1:0] i0, i1;
      set_root(FRAME_BITS'($urandom));
      i0 = SLOT_BITS'($urandom);
      i1 = SLOT_BITS'($urandom);
      send_write(root_frame_q, i0, make_entry(5, 10'h001, 10'h000));
      send_write(5, i1, make_entry(9, 10'h001, 10'h000));
      for (int s = 0; s < 8; s++)
         send_write(9, SLOT_BITS'(s), rand_leaf());
      gapless = 1'b1;
      hold_ticket <= hold_ticket + 1;
      for (int k = 0; k < 40; k++)
         send_walk(vpn_of(i0, i1, SLOT_BITS'($urandom_range(0, 9))));
      gapless = 1'b0;
   endtask

   initial begin
      foreach (table_mem[f, s])
         table_mem[f][s] = '0;
      root_frame_q = '0;
      mismatches   = 0;
      burst_left   = 0;
      gapless      = 1'b0;
      hold_ticket  = 0;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.action     <= ACTION_WRITE;
      req_if.frame      <= '0;
      req_if.slot       <= '0;
      req_if.entry_word <= '0;
      req_if.virt_page  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_tables();
      test_directed_paths();
      test_root_extremes();
      test_random_tables();
      test_backpressure();
      wait_drained();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // response side: changing stall modes plus an occasional long hold-off
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int hold_served;
      int hold_left;
      mode        = 0;
      mode_left   = 0;
      hold_served = 0;
      hold_left   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((mode_left % 8) < 5);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      ptw_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_walks.size() == 0) begin
            report_mismatch("transaction with no walk outstanding", 64'(rsp_if.found), '0);
         end else begin
            want = pending_walks.pop_front();
            if (rsp_if.found !== want.found)
               report_mismatch("found", 64'(rsp_if.found), 64'(want.found));
            if (rsp_if.leaf_frame !== want.leaf_frame)
               report_mismatch("leaf_frame", 64'(rsp_if.leaf_frame), 64'(want.leaf_frame));
            if (rsp_if.leaf_slot !== want.leaf_slot)
               report_mismatch("leaf_slot", 64'(rsp_if.leaf_slot), 64'(want.leaf_slot));
            if (rsp_if.leaf_entry !== want.leaf_entry)
               report_mismatch("leaf_entry", rsp_if.leaf_entry, want.leaf_entry);
            if (rsp_if.bad_frame !== want.bad_frame)
               report_mismatch("bad_frame", 64'(rsp_if.bad_frame), 64'(want.bad_frame));
         end
      end
   end

   // the allowed idle time also covers the clearing sweep after reset
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
